// File: sv/sphere_cone_vertex_select_defines.svh
// ----------------------------------------------------------------------------
// sphere_cone_vertex_select_defines.svh
// Assertion macros shared by the vertex select block.
// ----------------------------------------------------------------------------
`ifndef SPHERE_CONE_VERTEX_SELECT_DEFINES_SVH
`define SPHERE_CONE_VERTEX_SELECT_DEFINES_SVH

// plain property, sampled on i_clk, off while in reset
`define SCVS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define SCVS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/sphcv_pkg.sv
// ----------------------------------------------------------------------------
// sphcv_pkg
// Types and codes for the sphere / normal-cone vertex select block.
// ----------------------------------------------------------------------------
`default_nettype none

package sphcv_pkg;

    // verdict codes
    localparam logic [1:0] V_OUT   = 2'd0;
    localparam logic [1:0] V_COLL  = 2'd1;
    localparam logic [1:0] V_REJ   = 2'd2;
    localparam logic [1:0] V_AWAY  = 2'd3;

    // select modes
    localparam logic [1:0] MODE_ALL    = 2'd0;
    localparam logic [1:0] MODE_DIR    = 2'd1;

    // register indexes
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS2  = 3'd3;
    localparam logic [2:0] REG_DIR      = 3'd4;
    localparam logic [2:0] REG_COS      = 3'd5;
    localparam logic [2:0] REG_MODE     = 3'd6;

    localparam int CFG_W = 52;
    localparam int DIV_N = 40;          // dividend width of the shared divider

    localparam logic signed [15:0] NORM_ONE = 16'sd16384;

    typedef struct packed {
        logic        [15:0] vertex_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               to_be_removed;
        logic               last;
    } t_item;

    typedef struct packed {
        logic        [15:0] result_index;
        logic        [1:0]  verdict;
        logic               add_to_test_list;
        logic               batch_done;
        logic signed [23:0] avg_pos_x;
        logic signed [23:0] avg_pos_y;
        logic signed [23:0] avg_pos_z;
        logic signed [15:0] avg_normal_x;
        logic signed [15:0] avg_normal_y;
        logic signed [15:0] avg_normal_z;
    } t_res;

    // classified vertex passed from front to back
    typedef struct packed {
        logic        [15:0] vertex_index;
        logic        [1:0]  verdict;
        logic               in_range;
        logic               last;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_cls;

endpackage

`default_nettype wire

// File: sv/sphcv_fifo.sv
// ----------------------------------------------------------------------------
// sphcv_fifo
// Four-entry queue of classified vertices between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sphcv_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  sphcv_pkg::t_cls i_data,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_empty,
    output sphcv_pkg::t_cls o_data
);
    import sphcv_pkg::*;

    t_cls       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr_en, rd_en;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + 2'd1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'b0, wr_en} - {2'b0, rd_en};
        end
    end

endmodule

`default_nettype wire

// File: sv/sphcv_front.sv
// ----------------------------------------------------------------------------
// sphcv_front
// Config registers, range and cone test; two stages, products registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sphcv_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_idx,
    input  logic [sphcv_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                         i_push,
    input  sphcv_pkg::t_item             i_item,
    output logic                         o_full,
    output logic                         o_push,
    output sphcv_pkg::t_cls              o_cls,
    input  logic                         i_fifo_full
);
    import sphcv_pkg::*;

    logic signed [23:0] r_cx, r_cy, r_cz;
    logic        [51:0] r_rsq;
    logic        [47:0] r_dir;
    logic signed [15:0] r_cos;
    logic        [1:0]  r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_cz   <= '0;
            r_rsq  <= '0;
            r_dir  <= '0;
            r_cos  <= '0;
            r_mode <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_X: r_cx   <= i_cfg_data[23:0];
                REG_CENTER_Y: r_cy   <= i_cfg_data[23:0];
                REG_CENTER_Z: r_cz   <= i_cfg_data[23:0];
                REG_RADIUS2:  r_rsq  <= i_cfg_data[51:0];
                REG_DIR:      r_dir  <= i_cfg_data[47:0];
                REG_COS:      r_cos  <= i_cfg_data[15:0];
                REG_MODE:     r_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // stage 1: differences and products
    logic signed [24:0] dx, dy, dz;
    logic signed [49:0] dx2, dy2, dz2;
    logic signed [31:0] px, py, pz;
    logic               load;

    assign dx  = {i_item.pos_x[23], i_item.pos_x} - {r_cx[23], r_cx};
    assign dy  = {i_item.pos_y[23], i_item.pos_y} - {r_cy[23], r_cy};
    assign dz  = {i_item.pos_z[23], i_item.pos_z} - {r_cz[23], r_cz};
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;
    assign dz2 = dz * dz;
    assign px  = $signed(r_dir[15:0])  * i_item.normal_x;
    assign py  = $signed(r_dir[31:16]) * i_item.normal_y;
    assign pz  = $signed(r_dir[47:32]) * i_item.normal_z;

    logic               r1_v;
    t_item              r1;
    logic        [48:0] r_dx2, r_dy2, r_dz2;
    logic signed [31:0] r_px, r_py, r_pz;

    assign o_full = r1_v && i_fifo_full;
    assign o_push = r1_v && !i_fifo_full;
    assign load   = !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (load) begin
            r1_v <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_push) begin
            r1    <= i_item;
            r_dx2 <= dx2[48:0];
            r_dy2 <= dy2[48:0];
            r_dz2 <= dz2[48:0];
            r_px  <= px;
            r_py  <= py;
            r_pz  <= pz;
        end
    end

    // stage 2: compares and verdict
    logic        [49:0] d2;
    logic signed [33:0] dot, lim;
    logic               in_range, facing;
    logic        [1:0]  verdict;

    assign d2  = {1'b0, r_dx2} + {1'b0, r_dy2} + {1'b0, r_dz2};
    assign dot = {{2{r_px[31]}}, r_px} + {{2{r_py[31]}}, r_py} + {{2{r_pz[31]}}, r_pz};
    assign lim = {{4{r_cos[15]}}, r_cos, 14'b0};
    assign in_range = !r1.to_be_removed && ({2'b0, d2} < r_rsq);
    assign facing   = (dot >= lim);

    always_comb begin
        priority if (!in_range) begin
            verdict = V_OUT;
        end else if (r_mode == MODE_ALL || facing) begin
            verdict = V_COLL;
        end else if (r_mode == MODE_DIR) begin
            verdict = V_AWAY;
        end else begin
            verdict = V_REJ;
        end
    end

    always_comb begin
        o_cls.vertex_index = r1.vertex_index;
        o_cls.verdict      = verdict;
        o_cls.in_range     = in_range;
        o_cls.last         = r1.last;
        o_cls.pos_x        = r1.pos_x;
        o_cls.pos_y        = r1.pos_y;
        o_cls.pos_z        = r1.pos_z;
        o_cls.normal_x     = r1.normal_x;
        o_cls.normal_y     = r1.normal_y;
        o_cls.normal_z     = r1.normal_z;
    end

endmodule

`default_nettype wire

// File: sv/sphcv_div.sv
// ----------------------------------------------------------------------------
// sphcv_div
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module sphcv_div #(
    parameter int DW = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [2:0][sphcv_pkg::DIV_N-1:0]    i_num,
    input  logic [DW-1:0]                       i_den,
    output logic                                o_done,
    output logic [2:0][sphcv_pkg::DIV_N-1:0]    o_quot
);
    import sphcv_pkg::*;

    logic [5:0]                r_step;
    logic                      r_done;
    logic [DW-1:0]             r_den;
    logic [2:0][DIV_N-1:0]     r_num;
    logic [2:0][DW-1:0]        r_rem;
    logic [2:0][DW:0]          trial;
    logic [2:0]                ge;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            trial[i] = {r_rem[i], r_num[i][DIV_N-1]};
            ge[i]    = (trial[i] >= {1'b0, r_den});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_step == 6'd1);
            if (i_start) begin
                r_step <= 6'(DIV_N);
            end else if (r_step != 6'd0) begin
                r_step <= r_step - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_step != 6'd0) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= {r_num[i][DIV_N-2:0], ge[i]};
                r_rem[i] <= ge[i] ? DW'(trial[i] - {1'b0, r_den}) : trial[i][DW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

// File: sv/sphcv_back.sv
// ----------------------------------------------------------------------------
// sphcv_back
// Sums collected vertices, forms batch means, holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sphere_cone_vertex_select_defines.svh"

module sphcv_back #(
    parameter int MAX_VERTICES = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fifo_empty,
    input  sphcv_pkg::t_cls i_cls,
    output logic            o_fifo_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output sphcv_pkg::t_res o_result
);
    import sphcv_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DW = (CW > 25) ? CW : 25;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;
    localparam logic [3:0] ST_DIVP  = 4'd2;
    localparam logic [3:0] ST_NRM   = 4'd3;
    localparam logic [3:0] ST_SCALE = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_SUM   = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_DIVN  = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]              r_state;
    logic                    r_out_v;
    t_res                    r_out;
    logic [2:0][39:0]        r_sp;
    logic [2:0][31:0]        r_sn;
    logic [CW-1:0]           r_cnt;
    logic [15:0]             r_idx;
    logic [1:0]              r_verd;
    logic                    r_inr;
    logic [2:0][23:0]        r_avgp;
    logic [2:0][15:0]        r_avgn;
    logic [2:0][31:0]        r_m;
    logic [2:0][47:0]        r_sq;
    logic [49:0]             r_v, r_res, r_bit;

    logic                    slot_free, pop_acc, add, out_load;
    logic                    div_start, div_done;
    logic [2:0][DIV_N-1:0]   div_num, div_quot;
    logic [DW-1:0]           div_den;
    logic [50:0]             sq_try;
    logic                    any_hi, any_b23, all_zero;

    function automatic logic [23:0] mean_sat(input logic neg, input logic [39:0] q);
        logic [23:0] m;
        if (neg) begin
            m = (q > 40'h80_0000) ? 24'h80_0000 : q[23:0];
            return 24'(-m);
        end else begin
            return (q > 40'h7F_FFFF) ? 24'h7F_FFFF : q[23:0];
        end
    endfunction

    function automatic logic [15:0] norm_sat(input logic neg, input logic [39:0] q);
        logic [15:0] m;
        m = (q > 40'd16384) ? NORM_ONE : q[15:0];
        return neg ? 16'(-m) : m;
    endfunction

    assign pop_acc    = i_pop && r_out_v;
    assign slot_free  = !r_out_v || pop_acc;
    assign o_fifo_pop = (r_state == ST_IDLE) && !i_fifo_empty && slot_free;
    assign add        = o_fifo_pop && (i_cls.verdict == V_COLL) &&
                        (r_cnt < CW'(MAX_VERTICES));
    assign out_load   = (o_fifo_pop && !i_cls.last) ||
                        ((r_state == ST_DONE) && slot_free);
    assign o_empty    = !r_out_v;
    assign o_result   = r_out;

    assign any_hi   = (r_m[0][31:24] != '0) || (r_m[1][31:24] != '0) ||
                      (r_m[2][31:24] != '0);
    assign any_b23  = r_m[0][23] || r_m[1][23] || r_m[2][23];
    assign all_zero = (r_m[0] == '0) && (r_m[1] == '0) && (r_m[2] == '0);
    assign sq_try   = {1'b0, r_res} + {1'b0, r_bit};

    assign div_start = ((r_state == ST_CHK) && (r_cnt != '0)) ||
                       ((r_state == ST_SQRT) && (r_bit == '0));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_state == ST_CHK) begin
                div_num[i] = r_sp[i][39] ? 40'(-r_sp[i]) : r_sp[i];
            end else begin
                div_num[i] = {2'b0, r_m[i][23:0], 14'b0} + 40'(r_res[49:1]);
            end
        end
        div_den = (r_state == ST_CHK) ? DW'(r_cnt) : DW'(r_res[24:0]);
    end

    sphcv_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
            r_sp    <= '0;
            r_sn    <= '0;
            r_cnt   <= '0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (pop_acc) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_fifo_pop) begin
                        if (add) begin
                            r_sp[0] <= r_sp[0] + {{16{i_cls.pos_x[23]}}, i_cls.pos_x};
                            r_sp[1] <= r_sp[1] + {{16{i_cls.pos_y[23]}}, i_cls.pos_y};
                            r_sp[2] <= r_sp[2] + {{16{i_cls.pos_z[23]}}, i_cls.pos_z};
                            r_sn[0] <= r_sn[0] + {{16{i_cls.normal_x[15]}}, i_cls.normal_x};
                            r_sn[1] <= r_sn[1] + {{16{i_cls.normal_y[15]}}, i_cls.normal_y};
                            r_sn[2] <= r_sn[2] + {{16{i_cls.normal_z[15]}}, i_cls.normal_z};
                            r_cnt   <= r_cnt + CW'(1);
                        end
                        if (i_cls.last) begin
                            r_state <= ST_CHK;
                        end
                    end
                end
                ST_CHK:  r_state <= (r_cnt == '0) ? ST_DONE : ST_DIVP;
                ST_DIVP: if (div_done) r_state <= ST_NRM;
                ST_NRM:  r_state <= all_zero ? ST_DONE : ST_SCALE;
                ST_SCALE: if (!any_hi && any_b23) r_state <= ST_SQ;
                ST_SQ:   r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_SQRT;
                ST_SQRT: if (r_bit == '0) r_state <= ST_DIVN;
                ST_DIVN: if (div_done) r_state <= ST_DONE;
                ST_DONE: begin
                    if (slot_free) begin
                        r_sp    <= '0;
                        r_sn    <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_fifo_pop) begin
            r_idx  <= i_cls.vertex_index;
            r_verd <= i_cls.verdict;
            r_inr  <= i_cls.in_range;
            r_avgp <= '0;
            r_avgn <= '0;
            if (!i_cls.last) begin
                r_out <= '{result_index: i_cls.vertex_index, verdict: i_cls.verdict,
                           add_to_test_list: i_cls.in_range, batch_done: 1'b0,
                           default: '0};
            end
        end
        if (r_state == ST_CHK && r_cnt == '0) begin
            r_avgn[1] <= NORM_ONE;
        end
        if (r_state == ST_DIVP && div_done) begin
            for (int i = 0; i < 3; i++) begin
                r_avgp[i] <= mean_sat(r_sp[i][39], div_quot[i]);
                r_m[i]    <= r_sn[i][31] ? 32'(-r_sn[i]) : r_sn[i];
            end
        end
        if (r_state == ST_SCALE) begin
            for (int i = 0; i < 3; i++) begin
                if (any_hi) begin
                    r_m[i] <= r_m[i] >> 1;
                end else if (!any_b23) begin
                    r_m[i] <= r_m[i] << 1;
                end
            end
        end
        if (r_state == ST_SQ) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_m[i][23:0] * r_m[i][23:0];
            end
        end
        if (r_state == ST_SUM) begin
            r_v   <= {2'b0, r_sq[0]} + {2'b0, r_sq[1]} + {2'b0, r_sq[2]};
            r_res <= '0;
            r_bit <= 50'(1) << 48;
        end
        if (r_state == ST_SQRT && r_bit != '0) begin
            if ({1'b0, r_v} >= sq_try) begin
                r_v   <= 50'({1'b0, r_v} - sq_try);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (r_state == ST_DIVN && div_done) begin
            for (int i = 0; i < 3; i++) begin
                r_avgn[i] <= norm_sat(r_sn[i][31], div_quot[i]);
            end
        end
        if (r_state == ST_DONE && slot_free) begin
            r_out <= '{result_index: r_idx, verdict: r_verd, add_to_test_list: r_inr,
                       batch_done: 1'b1,
                       avg_pos_x: r_avgp[0], avg_pos_y: r_avgp[1], avg_pos_z: r_avgp[2],
                       avg_normal_x: r_avgn[0], avg_normal_y: r_avgn[1],
                       avg_normal_z: r_avgn[2]};
        end
    end

    `SCVS_ASSERT_IMPL(a_pop_only_idle, o_fifo_pop, r_state == ST_IDLE, "queue read while busy")
    `SCVS_ASSERT(a_cnt_bound, r_cnt <= CW'(MAX_VERTICES), "collected count beyond limit")
    `SCVS_ASSERT_IMPL(a_len_nonzero, div_start && r_state == ST_SQRT, r_res != '0, "zero length")
    `SCVS_ASSERT_IMPL(a_no_overwrite, r_state == ST_DONE && r_out_v && !i_pop, ##1 r_state == ST_DONE, "result overwritten")

endmodule

`default_nettype wire

// File: sv/sphere_cone_vertex_select.sv
// ----------------------------------------------------------------------------
// sphere_cone_vertex_select
// Radius query with a normal-cone filter over a stream of vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: present an item on i_item with push; it transfers when full
//   is low. Results queue: while empty is low, o_result holds the oldest
//   result; pop transfers it. One result per vertex, in order.
//   Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write one register per cycle,
//   only while no batch is in flight.
//   Flow: ordinary vertices pass the front stage register and the queue to
//   the result register; one vertex a cycle is sustained while results are
//   popped and no batch is closing. For the last vertex of a batch the back
//   end runs the position divide, normal scaling, the square root and the
//   normal divide; the front keeps taking items into the four-entry queue.
//   Reset clears config, sums and all queues. If the receiver stalls, the
//   result register holds, the queue fills and full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_cone_vertex_select #(
    parameter int MAX_VERTICES = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_idx,
    input  logic [sphcv_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  sphcv_pkg::t_item             i_item,
    input  logic                         pop,
    output logic                         empty,
    output sphcv_pkg::t_res              o_result
);
    import sphcv_pkg::*;

    logic fr_push, fifo_full, fifo_empty, fifo_pop;
    t_cls fr_cls, q_cls;

    sphcv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_push      (fr_push),
        .o_cls       (fr_cls),
        .i_fifo_full (fifo_full)
    );

    sphcv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fr_push),
        .i_data  (fr_cls),
        .o_full  (fifo_full),
        .i_rd    (fifo_pop),
        .o_empty (fifo_empty),
        .o_data  (q_cls)
    );

    sphcv_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (fifo_empty),
        .i_cls        (q_cls),
        .o_fifo_pop   (fifo_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire
